### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/deic_pkg.sv
// ----------------------------------------------------------------------------
// deic_pkg
// Types, codes and widths shared by the edge insert / closure block.
// ----------------------------------------------------------------------------
package deic_pkg;

    localparam int VERTICES_DEF = 64;
    localparam int VTX_W        = 6;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int EDGE_W       = 8;
    localparam int LIMIT_W      = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 2;

    // operation codes; the unused code behaves as a query
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CYCLE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_INDEGREE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_CYCLES_ALLOWED = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 2'd2;
    localparam logic               CYCLES_RESET = 1'b0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VTX_W-1:0]  parent_vertex;
        logic [VTX_W-1:0]  child_vertex;
    } t_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                reachable;
        logic [EDGE_W-1:0]   edge_total;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [LIMIT_W-1:0] indegree_limit;
        logic               cycles_allowed;
    } t_cfg;

    typedef struct packed {
        logic             first_valid;
        logic [VTX_W-1:0] first_parent;
        logic             second_valid;
        logic [VTX_W-1:0] second_parent;
    } t_slot;

endpackage

### rtl/deic_stream_if.sv
// ----------------------------------------------------------------------------
// deic_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface deic_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dag_edge_insert_closure_core.sv
// ----------------------------------------------------------------------------
// dag_edge_insert_closure_core
// Graph with two parent slots per vertex and a reachability bit matrix kept
// in synchronous RAM, updated incrementally on every accepted edge insert.
// ----------------------------------------------------------------------------
// Usage:
//   i_op  : operation transfers (func, parent_vertex, child_vertex). func
//           inserts an edge, queries reachability or clears the graph.
//   o_res : one result transfer per operation (status, reachable,
//           edge_total), held in an output register.
//   i_cfg : register writes (index, data); always ready, taken at once.
//           Write only while no operation is in flight.
// Sequencing:
//   query or refused insert : child row and parent row read, result formed
//   accepted insert         : both row reads, then one closure row read-
//                             modify-written per cycle through the row RAM port
//   clear                   : one row zeroed per cycle
// A new operation is taken while the previous result still waits in the
// output register. After reset the block zeroes all VERTICES rows and slot
// entries before i_op goes ready; config writes are taken during that pass.
// A stalled o_res holds its result, and at most one further finished result
// waits inside the sequencer until it drains.
// ----------------------------------------------------------------------------
module dag_edge_insert_closure_core #(
    parameter int VERTICES = deic_pkg::VERTICES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    deic_stream_if.sink   i_op,
    deic_stream_if.source o_res,
    deic_stream_if.sink   i_cfg
);

    localparam int AW = $clog2(VERTICES);
    localparam int SW = $bits(deic_pkg::t_slot);

    // configuration registers
    deic_pkg::t_cfg r_cfg, n_cfg;

    // output register between sequencer and o_res
    logic           r_out_valid, n_out_valid;
    deic_pkg::t_res r_out, n_out;

    logic           res_valid;
    logic           res_ready;
    deic_pkg::t_res res;

    // memory port wiring
    logic                row_re, row_we;
    logic [AW-1:0]       row_raddr, row_waddr;
    logic [VERTICES-1:0] row_rdata, row_wdata;
    logic                slot_re, slot_we;
    logic [AW-1:0]       slot_raddr, slot_waddr;
    deic_pkg::t_slot     slot_rdata, slot_wdata;
    logic [SW-1:0]       slot_rdata_raw;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.data.index)
                deic_pkg::CFG_REG_INDEGREE_LIMIT: begin
                    n_cfg.indegree_limit = i_cfg.data.data[deic_pkg::LIMIT_W-1:0];
                end
                deic_pkg::CFG_REG_CYCLES_ALLOWED: begin
                    n_cfg.cycles_allowed = i_cfg.data.data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // load a fresh result when the register is empty or draining
    assign res_ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.indegree_limit <= deic_pkg::LIMIT_RESET;
            r_cfg.cycles_allowed <= deic_pkg::CYCLES_RESET;
            r_out_valid          <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    deic_ctrl #(
        .VERTICES (VERTICES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (i_op.valid),
        .o_op_ready   (i_op.ready),
        .i_op         (i_op.data),
        .i_cfg        (r_cfg),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_row_re     (row_re),
        .o_row_raddr  (row_raddr),
        .i_row_rdata  (row_rdata),
        .o_row_we     (row_we),
        .o_row_waddr  (row_waddr),
        .o_row_wdata  (row_wdata),
        .o_slot_re    (slot_re),
        .o_slot_raddr (slot_raddr),
        .i_slot_rdata (slot_rdata),
        .o_slot_we    (slot_we),
        .o_slot_waddr (slot_waddr),
        .o_slot_wdata (slot_wdata)
    );

    // closure matrix: one row per vertex
    deic_ram #(
        .WIDTH (VERTICES),
        .DEPTH (VERTICES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata)
    );

    // parent slots: both slots of a vertex in one entry
    deic_ram #(
        .WIDTH (SW),
        .DEPTH (VERTICES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata_raw),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata)
    );

    assign slot_rdata = deic_pkg::t_slot'(slot_rdata_raw);

endmodule

### rtl/deic_ram.sv
// ----------------------------------------------------------------------------
// deic_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module deic_ram #(
    parameter int WIDTH = deic_pkg::VERTICES_DEF,
    parameter int DEPTH = deic_pkg::VERTICES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/deic_ctrl.sv
// ----------------------------------------------------------------------------
// deic_ctrl
// Operation sequencer: checks inserts against the slot and closure memories,
// sweeps the closure rows on an accepted insert and runs the clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deic_ctrl #(
    parameter int VERTICES = deic_pkg::VERTICES_DEF,
    localparam int AW      = $clog2(VERTICES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // operation channel
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  deic_pkg::t_op       i_op,
    // configuration
    input  deic_pkg::t_cfg      i_cfg,
    // result channel
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output deic_pkg::t_res      o_res,
    // closure row memory
    output logic                o_row_re,
    output logic [AW-1:0]       o_row_raddr,
    input  logic [VERTICES-1:0] i_row_rdata,
    output logic                o_row_we,
    output logic [AW-1:0]       o_row_waddr,
    output logic [VERTICES-1:0] o_row_wdata,
    // parent slot memory
    output logic                o_slot_re,
    output logic [AW-1:0]       o_slot_raddr,
    input  deic_pkg::t_slot     i_slot_rdata,
    output logic                o_slot_we,
    output logic [AW-1:0]       o_slot_waddr,
    output deic_pkg::t_slot     o_slot_wdata
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD_C  = 6'b000100,
        ST_RD_P  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    localparam logic [AW-1:0]       LAST_IDX = AW'(VERTICES - 1);
    localparam logic [AW-1:0]       IDX_ONE  = AW'(1);
    localparam logic [VERTICES-1:0] ROW_ONE  = VERTICES'(1);
    localparam logic [deic_pkg::EDGE_W-1:0] EDGE_ONE = deic_pkg::EDGE_W'(1);

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_idx, n_idx;
    logic                          r_op_clear, n_op_clear;
    logic [deic_pkg::EDGE_W-1:0]   r_edge_count, n_edge_count;
    deic_pkg::t_op                 r_op, n_op;
    logic [VERTICES-1:0]           r_src, n_src;
    logic                          r_c_reach_p, n_c_reach_p;
    deic_pkg::t_res                r_res, n_res;

    logic [AW-1:0]                 p_addr;
    logic [AW-1:0]                 c_addr;
    logic                          in_range;
    logic [1:0]                    deg;
    logic [deic_pkg::STATUS_W-1:0] ins_status;
    deic_pkg::t_slot               slot_new;
    logic                          row_hit;

    assign p_addr   = AW'(r_op.parent_vertex);
    assign c_addr   = AW'(r_op.child_vertex);
    assign in_range = (32'(r_op.parent_vertex) < 32'(VERTICES))
                   && (32'(r_op.child_vertex) < 32'(VERTICES));
    assign deg      = {1'b0, i_slot_rdata.first_valid} + {1'b0, i_slot_rdata.second_valid};
    assign row_hit  = (r_idx == p_addr) || i_row_rdata[p_addr];

    // refusal checks in priority order
    always_comb begin
        if (!in_range) begin
            ins_status = deic_pkg::STATUS_FULL;
        end else if ((i_cfg.indegree_limit != '0) && (i_cfg.indegree_limit <= deg)) begin
            ins_status = deic_pkg::STATUS_LIMIT;
        end else if (deg >= 2'd2) begin
            ins_status = deic_pkg::STATUS_FULL;
        end else if (!i_cfg.cycles_allowed
                     && ((r_op.parent_vertex == r_op.child_vertex) || r_c_reach_p)) begin
            ins_status = deic_pkg::STATUS_CYCLE;
        end else begin
            ins_status = deic_pkg::STATUS_DONE;
        end
    end

    // fill the first free slot
    always_comb begin
        slot_new = i_slot_rdata;
        if (!i_slot_rdata.first_valid) begin
            slot_new.first_valid  = 1'b1;
            slot_new.first_parent = r_op.parent_vertex;
        end else begin
            slot_new.second_valid  = 1'b1;
            slot_new.second_parent = r_op.parent_vertex;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_op_clear   = r_op_clear;
        n_edge_count = r_edge_count;
        n_op         = r_op;
        n_src        = r_src;
        n_c_reach_p  = r_c_reach_p;
        n_res        = r_res;
        o_op_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_row_re     = 1'b0;
        o_row_raddr  = r_idx;
        o_row_we     = 1'b0;
        o_row_waddr  = r_idx;
        o_row_wdata  = '0;
        o_slot_re    = 1'b0;
        o_slot_raddr = AW'(i_op.child_vertex);
        o_slot_we    = 1'b0;
        o_slot_waddr = r_idx;
        o_slot_wdata = '0;

        case (r_state)
            ST_CLEAR: begin
                // zero one row and one slot entry per cycle
                o_row_we  = 1'b1;
                o_slot_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    if (r_op_clear) begin
                        n_op_clear       = 1'b0;
                        n_res.status     = deic_pkg::STATUS_DONE;
                        n_res.reachable  = 1'b0;
                        n_res.edge_total = '0;
                        n_state          = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IDX_ONE;
                end
            end
            ST_IDLE: begin
                o_op_ready = 1'b1;
                if (i_op_valid) begin
                    n_op = i_op;
                    if (i_op.func == deic_pkg::FUNC_CLEAR) begin
                        n_op_clear   = 1'b1;
                        n_idx        = '0;
                        n_edge_count = '0;
                        n_state      = ST_CLEAR;
                    end else begin
                        o_row_re    = 1'b1;
                        o_row_raddr = AW'(i_op.child_vertex);
                        o_slot_re   = 1'b1;
                        n_state     = ST_RD_C;
                    end
                end
            end
            ST_RD_C: begin
                // hold the child's row as the OR source, then fetch the parent row
                n_src       = i_row_rdata | (ROW_ONE << c_addr);
                n_c_reach_p = i_row_rdata[p_addr];
                o_row_re    = 1'b1;
                o_row_raddr = p_addr;
                n_state     = ST_RD_P;
            end
            ST_RD_P: begin
                n_res.status     = deic_pkg::STATUS_DONE;
                n_res.reachable  = in_range && i_row_rdata[c_addr];
                n_res.edge_total = r_edge_count;
                n_state          = ST_DONE;
                if (r_op.func == deic_pkg::FUNC_INSERT) begin
                    n_res.status = ins_status;
                    if (ins_status == deic_pkg::STATUS_DONE) begin
                        o_slot_we        = 1'b1;
                        o_slot_waddr     = c_addr;
                        o_slot_wdata     = slot_new;
                        n_edge_count     = r_edge_count + EDGE_ONE;
                        n_res.edge_total = r_edge_count + EDGE_ONE;
                        n_res.reachable  = 1'b1;
                        o_row_re         = 1'b1;
                        o_row_raddr      = '0;
                        n_idx            = '0;
                        n_state          = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                // write back row r_idx if it is or reaches the parent, while reading the next one
                if (row_hit) begin
                    o_row_we    = 1'b1;
                    o_row_wdata = i_row_rdata | r_src;
                end
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_DONE;
                end else begin
                    o_row_re    = 1'b1;
                    o_row_raddr = r_idx + IDX_ONE;
                    n_idx       = r_idx + IDX_ONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_idx        <= '0;
            r_op_clear   <= 1'b0;
            r_edge_count <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_op_clear   <= n_op_clear;
            r_edge_count <= n_edge_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_src       <= n_src;
        r_c_reach_p <= n_c_reach_p;
        r_res       <= n_res;
    end

    assign o_res = r_res;

    `ASSERT_IMPL(a_sweep_wb_addr, i_clk, i_rst_n, (r_state == ST_SWEEP) && o_row_we, o_row_waddr == $past(o_row_raddr), "sweep write-back address differs from the row read")
    `ASSERT_IMPL(a_edge_count_step, i_clk, i_rst_n, r_edge_count != $past(r_edge_count), (r_edge_count == ($past(r_edge_count) + EDGE_ONE)) || (r_edge_count == '0), "edge count moved by other than one or zero")
    `ASSERT_IMPL(a_refused_keeps_count, i_clk, i_rst_n, $rose(o_res_valid) && (o_res.status != deic_pkg::STATUS_DONE), $stable(r_edge_count), "refused insert changed the edge count")
    `ASSERT_NEXT(a_clear_starts_pass, i_clk, i_rst_n, o_op_ready && i_op_valid && (i_op.func == deic_pkg::FUNC_CLEAR), (r_state == ST_CLEAR) && (r_edge_count == '0), "clear did not start the clearing pass")

endmodule
